@@ design/assert_macros.svh @@
// Assertion macros used by the checker file tsr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, including edges during reset.
`define TSR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// Checked only while reset is low.
`define TSR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`endif

@@ design/tsr_pkg.sv @@
// Shared constants and types for the tangent Sampson residual pipeline.
package tsr_pkg;

   localparam int DW  = 106;  // denominator width, scale 2^-60
   localparam int NW  = 105;  // squared numerator width
   localparam int QW  = 64;   // quotient / score width
   localparam int DLW = 32;   // dividend bits below the initial remainder
   localparam int DIV_STEPS = QW;

   localparam logic [2:0] CSR_ROW0_A  = 3'd0;
   localparam logic [2:0] CSR_ROW0_B  = 3'd1;
   localparam logic [2:0] CSR_ROW1_B  = 3'd2;
   localparam logic [2:0] CSR_ROW2_A  = 3'd3;
   localparam logic [2:0] CSR_LAST    = 3'd4;
   localparam logic [2:0] CSR_FOCAL   = 3'd5;
   localparam logic [2:0] CSR_FLOOR   = 3'd6;

   typedef struct packed {
      logic           bad;
      logic           over;
      logic [DW-1:0]  den;
      logic [DW-1:0]  rem;
      logic [DLW-1:0] dl;
      logic [QW-1:0]  q;
   } div_type;

endpackage

@@ design/tangent_sampson_residual.sv @@
// Tangent Sampson residual: one correspondence accepted per clock while req_stall is low, fully
// pipelined; a request passes through 8 arithmetic stages, 64 one-bit divider stages and the
// output register. A one-entry skid buffer behind the output register lets the pipe
// take one more request while a result is stalled; req_stall rises only when that buffer is full.
module tangent_sampson_residual (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pix_x,
   input  logic signed [31:0]  req_pix_y,
   input  logic signed [31:0]  req_ray_x,
   input  logic signed [31:0]  req_ray_y,
   input  logic signed [31:0]  req_ray_z,
   input  logic signed [31:0]  req_jac_00,
   input  logic signed [31:0]  req_jac_01,
   input  logic signed [31:0]  req_jac_10,
   input  logic signed [31:0]  req_jac_11,
   input  logic signed [31:0]  req_jac_20,
   input  logic signed [31:0]  req_jac_21,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [63:0]         rsp_score,
   output logic                rsp_score_valid
);

   // configuration
   logic [63:0] row0_a_ff, row0_b_ff, row1_b_ff, row2_a_ff;
   logic [31:0] last_ff, focal_ff, floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_a_ff <= '0;
         row0_b_ff <= '0;
         row1_b_ff <= '0;
         row2_a_ff <= '0;
         last_ff   <= '0;
         focal_ff  <= '0;
         floor_ff  <= 32'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            tsr_pkg::CSR_ROW0_A: row0_a_ff <= csr_wdata;
            tsr_pkg::CSR_ROW0_B: row0_b_ff <= csr_wdata;
            tsr_pkg::CSR_ROW1_B: row1_b_ff <= csr_wdata;
            tsr_pkg::CSR_ROW2_A: row2_a_ff <= csr_wdata;
            tsr_pkg::CSR_LAST:   last_ff   <= csr_wdata[31:0];
            tsr_pkg::CSR_FOCAL:  focal_ff  <= csr_wdata[31:0];
            tsr_pkg::CSR_FLOOR:  floor_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // mixed matrix: first two columns scaled by the reciprocal focal
   logic signed [31:0] e_w [3][3];
   logic signed [64:0] msc [3][2];
   logic signed [31:0] mat_in [3][3];
   logic signed [31:0] mat_ff [3][3];

   always_comb begin
      e_w[0][0] = $signed(row0_a_ff[31:0]);
      e_w[0][1] = $signed(row0_a_ff[63:32]);
      e_w[0][2] = $signed(row0_b_ff[31:0]);
      e_w[1][0] = $signed(row0_b_ff[63:32]);
      e_w[1][1] = $signed(row1_b_ff[31:0]);
      e_w[1][2] = $signed(row1_b_ff[63:32]);
      e_w[2][0] = $signed(row2_a_ff[31:0]);
      e_w[2][1] = $signed(row2_a_ff[63:32]);
      e_w[2][2] = $signed(last_ff);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 2; c++) begin
            msc[r][c]    = e_w[r][c] * $signed({1'b0, focal_ff});
            mat_in[r][c] = msc[r][c][63:32];
         end
         mat_in[r][2] = e_w[r][2];
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   // pipeline control
   logic en;
   logic skid_v_ff;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // stage 1: request capture
   logic signed [31:0] px1_ff, py1_ff;
   logic signed [31:0] ray1_ff [3];
   logic signed [31:0] jac1_ff [3][2];

   // stage 2: first products
   logic signed [63:0] pa_in [3], pb_in [3], pa2_ff [3], pb2_ff [3];
   logic signed [63:0] lp_in [2][3], lp2_ff [2][3];
   logic signed [31:0] ray2_ff [3];
   logic signed [31:0] jac2_ff [3][2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         pa_in[r] = mat_ff[r][0] * px1_ff;
         pb_in[r] = mat_ff[r][1] * py1_ff;
         for (int c = 0; c < 2; c++) begin
            lp_in[c][r] = mat_ff[r][c] * ray1_ff[r];
         end
      end
   end

   // stage 3: m = M*x1 and line head l
   logic signed [64:0] lsum [2];
   logic signed [49:0] mv_in [3], mv3_ff [3];
   logic signed [34:0] l_in [2], l3_ff [2];
   logic signed [31:0] ray3_ff [3];
   logic signed [31:0] jac3_ff [3][2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mv_in[r] = 50'(pa2_ff[r] >>> 16) + 50'(pb2_ff[r] >>> 16) + 50'(mat_ff[r][2]);
      end
      for (int c = 0; c < 2; c++) begin
         lsum[c] = 65'(lp2_ff[c][0]) + 65'(lp2_ff[c][1]) + 65'(lp2_ff[c][2]);
         l_in[c] = 35'(lsum[c] >>> 30);
      end
   end

   // stage 4: partial products against m (split in a high and low part)
   logic signed [24:0] mh [3];
   logic signed [25:0] ml [3];
   logic signed [57:0] nph_in [3], npl_in [3], nph4_ff [3], npl4_ff [3];
   logic signed [57:0] gph_in [2][3], gpl_in [2][3], gph4_ff [2][3], gpl4_ff [2][3];
   logic signed [69:0] lsq_w [2];
   logic [68:0] lsq_in [2], lsq4_ff [2], lsq5_ff [2], lsq6_ff [2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mh[r]     = $signed(mv3_ff[r][49:25]);
         ml[r]     = $signed({1'b0, mv3_ff[r][24:0]});
         nph_in[r] = ray3_ff[r] * mh[r];
         npl_in[r] = ray3_ff[r] * ml[r];
         for (int c = 0; c < 2; c++) begin
            gph_in[c][r] = jac3_ff[r][c] * mh[r];
            gpl_in[c][r] = jac3_ff[r][c] * ml[r];
         end
      end
      for (int c = 0; c < 2; c++) begin
         lsq_w[c]  = l3_ff[c] * l3_ff[c];
         lsq_in[c] = lsq_w[c][68:0];
      end
   end

   // stage 5: numerator n and gradient g
   logic signed [83:0] nsum;
   logic signed [83:0] gsum [2];
   logic signed [52:0] x_in [3], x5_ff [3];  // n, g0, g1

   always_comb begin
      nsum = '0;
      for (int r = 0; r < 3; r++) begin
         nsum = nsum + (84'(nph4_ff[r]) <<< 25) + 84'(npl4_ff[r]);
      end
      x_in[0] = 53'(nsum >>> 30);
      for (int c = 0; c < 2; c++) begin
         gsum[c] = '0;
         for (int r = 0; r < 3; r++) begin
            gsum[c] = gsum[c] + (84'(gph4_ff[c][r]) <<< 25) + 84'(gpl4_ff[c][r]);
         end
         x_in[c+1] = 53'(gsum[c] >>> 30);
      end
   end

   // stage 6: squares from three narrow partial products each
   logic signed [25:0] xh [3];
   logic signed [27:0] xl [3];
   logic signed [51:0] hh_in [3], hh6_ff [3];
   logic signed [53:0] hl_in [3], hl6_ff [3];
   logic [53:0] ll_in [3], ll6_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         xh[k]    = $signed(x5_ff[k][52:27]);
         xl[k]    = $signed({1'b0, x5_ff[k][26:0]});
         hh_in[k] = xh[k] * xh[k];
         hl_in[k] = xh[k] * xl[k];
         ll_in[k] = x5_ff[k][26:0] * x5_ff[k][26:0];
      end
   end

   // stage 7: n^2 and the denominator
   logic [109:0] sq [3];
   logic [tsr_pkg::NW-1:0] nsq_in, nsq7_ff;
   logic [tsr_pkg::DW-1:0] den_in, den7_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k] = 110'(unsigned'(110'(hh6_ff[k]) <<< 54)) + 110'(unsigned'(110'(hl6_ff[k]) <<< 28))
               + 110'(ll6_ff[k]);
      end
      nsq_in = sq[0][tsr_pkg::NW-1:0];
      den_in = tsr_pkg::DW'(sq[1][tsr_pkg::NW-1:0]) + tsr_pkg::DW'(sq[2][tsr_pkg::NW-1:0])
             + tsr_pkg::DW'(lsq6_ff[0]) + tsr_pkg::DW'(lsq6_ff[1]);
   end

   // stage 8: floor and overflow checks, divider setup
   tsr_pkg::div_type div0_in;
   logic             div_v [tsr_pkg::DIV_STEPS+1];
   tsr_pkg::div_type div_d [tsr_pkg::DIV_STEPS+1];
   logic             dv0_ff;
   tsr_pkg::div_type dd0_ff;

   always_comb begin
      div0_in.bad  = (focal_ff == '0) || (den7_ff <= tsr_pkg::DW'(floor_ff));
      // quotient reaches 2^64 when n^2 >= den * 2^32
      div0_in.over = {33'd0, nsq7_ff} >= {den7_ff, 32'd0};
      div0_in.den  = den7_ff;
      div0_in.rem  = tsr_pkg::DW'(nsq7_ff[tsr_pkg::NW-1:tsr_pkg::DLW]);
      div0_in.dl   = nsq7_ff[tsr_pkg::DLW-1:0];
      div0_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         dv0_ff <= 1'b0;
      end else if (en) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         dv0_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px1_ff        <= req_pix_x;
         py1_ff        <= req_pix_y;
         ray1_ff[0]    <= req_ray_x;
         ray1_ff[1]    <= req_ray_y;
         ray1_ff[2]    <= req_ray_z;
         jac1_ff[0][0] <= req_jac_00;
         jac1_ff[0][1] <= req_jac_01;
         jac1_ff[1][0] <= req_jac_10;
         jac1_ff[1][1] <= req_jac_11;
         jac1_ff[2][0] <= req_jac_20;
         jac1_ff[2][1] <= req_jac_21;
         pa2_ff  <= pa_in;
         pb2_ff  <= pb_in;
         lp2_ff  <= lp_in;
         ray2_ff <= ray1_ff;
         jac2_ff <= jac1_ff;
         mv3_ff  <= mv_in;
         l3_ff   <= l_in;
         ray3_ff <= ray2_ff;
         jac3_ff <= jac2_ff;
         nph4_ff <= nph_in;
         npl4_ff <= npl_in;
         gph4_ff <= gph_in;
         gpl4_ff <= gpl_in;
         lsq4_ff <= lsq_in;
         x5_ff   <= x_in;
         lsq5_ff <= lsq4_ff;
         hh6_ff  <= hh_in;
         hl6_ff  <= hl_in;
         ll6_ff  <= ll_in;
         lsq6_ff <= lsq5_ff;
         nsq7_ff <= nsq_in;
         den7_ff <= den_in;
         dd0_ff  <= div0_in;
      end
   end

   assign div_v[0] = dv0_ff;
   assign div_d[0] = dd0_ff;

   for (genvar k = 0; k < tsr_pkg::DIV_STEPS; k++) begin : g_div
      tsr_div_step u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in_v  (div_v[k]),
         .in_d  (div_d[k]),
         .out_v (div_v[k+1]),
         .out_d (div_d[k+1])
      );
   end

   // output register with one-entry skid
   logic [63:0] fin_score;
   logic        fin_sv;
   logic        incoming, take;
   logic        out_v_ff, out_v_in, skid_v_in;
   logic [63:0] out_score_ff, out_score_in, skid_score_ff, skid_score_in;
   logic        out_sv_ff, out_sv_in, skid_sv_ff, skid_sv_in;

   always_comb begin
      fin_score = (div_d[tsr_pkg::DIV_STEPS].bad || div_d[tsr_pkg::DIV_STEPS].over)
                ? '1 : div_d[tsr_pkg::DIV_STEPS].q;
      fin_sv    = !div_d[tsr_pkg::DIV_STEPS].bad;
      incoming  = en && div_v[tsr_pkg::DIV_STEPS];
      take      = out_v_ff && !rsp_stall;
      out_v_in      = out_v_ff;
      out_score_in  = out_score_ff;
      out_sv_in     = out_sv_ff;
      skid_v_in     = skid_v_ff;
      skid_score_in = skid_score_ff;
      skid_sv_in    = skid_sv_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_score_in = skid_score_ff;
            out_sv_in    = skid_sv_ff;
            skid_v_in    = 1'b0;
         end
      end else if (incoming) begin
         if (out_v_ff && !take) begin
            skid_v_in     = 1'b1;
            skid_score_in = fin_score;
            skid_sv_in    = fin_sv;
         end else begin
            out_v_in     = 1'b1;
            out_score_in = fin_score;
            out_sv_in    = fin_sv;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_score_ff  <= out_score_in;
      out_sv_ff     <= out_sv_in;
      skid_score_ff <= skid_score_in;
      skid_sv_ff    <= skid_sv_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_score       = out_score_ff;
   assign rsp_score_valid = out_sv_ff;

endmodule

@@ design/tsr_div_step.sv @@
// One restoring division step: one quotient bit per pipeline stage.
module tsr_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_v,
   input  tsr_pkg::div_type in_d,
   output logic             out_v,
   output tsr_pkg::div_type out_d
);

   logic [tsr_pkg::DW:0] shifted;
   logic                 ge;
   logic [tsr_pkg::DW:0] diff;
   tsr_pkg::div_type     d_in;
   logic                 v_ff;
   tsr_pkg::div_type     d_ff;

   always_comb begin
      shifted = {in_d.rem, in_d.dl[tsr_pkg::DLW-1]};
      ge      = shifted >= {1'b0, in_d.den};
      diff    = shifted - {1'b0, in_d.den};
      d_in      = in_d;
      d_in.rem  = ge ? diff[tsr_pkg::DW-1:0] : shifted[tsr_pkg::DW-1:0];
      d_in.q    = {in_d.q[tsr_pkg::QW-2:0], ge};
      d_in.dl   = {in_d.dl[tsr_pkg::DLW-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign out_v = v_ff;
   assign out_d = d_ff;

endmodule

@@ design/tsr_checker.sv @@
// Port-level checks for the tangent Sampson residual block, bound to the top level.
`include "assert_macros.svh"

module tsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_score,
   input logic        rsp_score_valid
);

   // reset empties the output side and frees the input
   `TSR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid && !req_stall)

   // a rejected correspondence always carries the maximum score
   `TSR_ASSERT(a_invalid_max, clock, reset, rsp_valid && !rsp_score_valid |-> &rsp_score)

   // a stalled result is held
   `TSR_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score))

   // input backs up only while a result is being held off
   `TSR_ASSERT(a_stall_cause, clock, reset, $rose(req_stall) |-> $past(rsp_valid && rsp_stall))

endmodule

bind tangent_sampson_residual tsr_checker u_tsr_checker (.*);
